### rtl/core/bbc_pkg.sv
// shared types, widths and codes for the lru buffer cache
package bbc_pkg;

	localparam int ENTRIES = 32;
	localparam int SLOT_W  = 5;
	localparam int DEV_W   = 8;
	localparam int BLK_W   = 32;
	localparam int CNT_W   = 8;
	localparam int STAT_W  = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef logic [SLOT_W-1:0]  slot_t;
	typedef logic [DEV_W-1:0]   dev_t;
	typedef logic [BLK_W-1:0]   blk_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [STAT_W-1:0]  stat_t;
	typedef logic [ENTRIES-1:0] vec_t;

	// request kinds
	localparam logic KIND_ACQ = 1'b0;
	localparam logic KIND_REL = 1'b1;

	// result status codes
	localparam stat_t ST_OK      = 2'd0;
	localparam stat_t ST_NO_FREE = 2'd1;
	localparam stat_t ST_UNREF   = 2'd2;

	// cell update operations
	localparam logic [1:0] OP_HOLD = 2'd0;
	localparam logic [1:0] OP_HIT  = 2'd1;
	localparam logic [1:0] OP_FILL = 2'd2;
	localparam logic [1:0] OP_DROP = 2'd3;

	typedef struct packed {
		slot_t id;
		dev_t  dev;
		blk_t  blk;
		logic  valid;
		cnt_t  cnt;
	} entry_t;

	typedef struct packed {
		logic       shift;
		logic [1:0] op;
	} cell_ctl_t;

endpackage

### rtl/core/bbc_cell.sv
// one recency position of the cache: entry storage, tag compare and update
module bbc_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  bbc_pkg::slot_t     init_slot,
	input  logic               cmp_kind,
	input  bbc_pkg::dev_t      cmp_dev,
	input  bbc_pkg::blk_t      cmp_blk,
	input  bbc_pkg::slot_t     cmp_slot,
	input  bbc_pkg::dev_t      fill_dev,
	input  bbc_pkg::blk_t      fill_blk,
	input  bbc_pkg::cell_ctl_t ctl,
	input  bbc_pkg::entry_t    prev,
	output bbc_pkg::entry_t    ent,
	output logic               match,
	output logic               free
);

	bbc_pkg::entry_t ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q.id    <= init_slot;
			ent_q.dev   <= '0;
			ent_q.blk   <= '0;
			ent_q.valid <= 1'b0;
			ent_q.cnt   <= '0;
		end else if (ctl.shift) begin
			ent_q <= prev;
		end else begin
			unique case (ctl.op)
				bbc_pkg::OP_HIT: begin
					ent_q.valid <= 1'b1;
					if (ent_q.cnt != bbc_pkg::CNT_MAX) begin
						ent_q.cnt <= ent_q.cnt + 1'b1;
					end
				end
				bbc_pkg::OP_FILL: begin
					ent_q.dev   <= fill_dev;
					ent_q.blk   <= fill_blk;
					ent_q.valid <= 1'b1;
					ent_q.cnt   <= bbc_pkg::CNT_W'(1);
				end
				bbc_pkg::OP_DROP: begin
					ent_q.cnt <= ent_q.cnt - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign ent   = ent_q;
	assign match = (cmp_kind == bbc_pkg::KIND_REL) ? (ent_q.id == cmp_slot)
		: ((ent_q.dev == cmp_dev) && (ent_q.blk == cmp_blk));
	assign free  = (ent_q.cnt == '0);

endmodule

### rtl/core/bbc_select.sv
// picks most recent match, least recent free entry and the move-to-front span
module bbc_select (
	input  bbc_pkg::vec_t match,
	input  bbc_pkg::vec_t free,
	output bbc_pkg::vec_t hit_oh,
	output bbc_pkg::vec_t lru_oh,
	output bbc_pkg::vec_t front_mask
);

	bbc_pkg::vec_t free_rev;
	bbc_pkg::vec_t lru_rev;

	// position 0 is most recent, so lowest set bit wins
	assign hit_oh = match & (~match + 1'b1);

	always_comb begin
		for (int i = 0; i < bbc_pkg::ENTRIES; i++) begin
			free_rev[i] = free[bbc_pkg::ENTRIES-1-i];
		end
	end

	assign lru_rev = free_rev & (~free_rev + 1'b1);

	always_comb begin
		for (int i = 0; i < bbc_pkg::ENTRIES; i++) begin
			lru_oh[i] = lru_rev[bbc_pkg::ENTRIES-1-i];
		end
	end

	// positions 0 up to and including the hit
	assign front_mask = hit_oh | (hit_oh - 1'b1);

endmodule

### rtl/core/block_buffer_cache_lru.sv
// lru buffer cache with reference counts, a chain of 32 recency cells
// the result is registered when the select and update step commits, after the input transaction is accepted
// a new transaction is accepted only after the previous one commits; compare step, then select and update step
// the update waits while a previous result is stalled on the output register
// reset: zero tags, invalid entries, zero counts, recency order slot 31 first, slot 0 last
module block_buffer_cache_lru (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  kind,
	input  bbc_pkg::dev_t         dev,
	input  bbc_pkg::blk_t         block_number,
	input  bbc_pkg::slot_t        slot,
	output logic                  out_valid,
	input  logic                  out_stall,
	output bbc_pkg::slot_t        slot_out,
	output logic                  need_read,
	output bbc_pkg::stat_t        status
);

	logic            busy_q;
	logic            out_valid_q;
	logic            req_kind_q;
	bbc_pkg::dev_t   req_dev_q;
	bbc_pkg::blk_t   req_blk_q;
	bbc_pkg::slot_t  req_slot_q;
	bbc_pkg::vec_t   match_q;
	bbc_pkg::slot_t  slot_out_q;
	logic            need_read_q;
	bbc_pkg::stat_t  status_q;

	bbc_pkg::entry_t    ent   [bbc_pkg::ENTRIES];
	bbc_pkg::entry_t    prev  [bbc_pkg::ENTRIES];
	bbc_pkg::cell_ctl_t ctl   [bbc_pkg::ENTRIES];
	bbc_pkg::vec_t      match_v;
	bbc_pkg::vec_t      free_v;
	bbc_pkg::vec_t      hit_oh;
	bbc_pkg::vec_t      lru_oh;
	bbc_pkg::vec_t      front_mask;
	bbc_pkg::vec_t      tgt_oh;
	bbc_pkg::entry_t    tgt_ent;
	bbc_pkg::entry_t    mover;

	logic            accept;
	logic            commit;
	logic            any_hit;
	logic            any_free;
	logic            do_op;
	logic            do_move;
	logic [1:0]      op;
	bbc_pkg::slot_t  res_slot;
	logic            res_need;
	bbc_pkg::stat_t  res_status;

	assign in_stall = busy_q;
	assign accept   = in_valid && !busy_q;
	assign commit   = busy_q && !(out_valid_q && out_stall);

	genvar g;
	generate
		for (g = 0; g < bbc_pkg::ENTRIES; g++) begin : g_cell
			if (g == 0) begin : g_head
				assign prev[g] = mover;
			end else begin : g_body
				assign prev[g] = ent[g-1];
			end

			bbc_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.init_slot (bbc_pkg::SLOT_W'(bbc_pkg::ENTRIES - 1 - g)),
				.cmp_kind  (kind),
				.cmp_dev   (dev),
				.cmp_blk   (block_number),
				.cmp_slot  (slot),
				.fill_dev  (req_dev_q),
				.fill_blk  (req_blk_q),
				.ctl       (ctl[g]),
				.prev      (prev[g]),
				.ent       (ent[g]),
				.match     (match_v[g]),
				.free      (free_v[g])
			);
		end
	endgenerate

	bbc_select u_select (
		.match      (match_q),
		.free       (free_v),
		.hit_oh     (hit_oh),
		.lru_oh     (lru_oh),
		.front_mask (front_mask)
	);

	assign any_hit  = |match_q;
	assign any_free = |free_v;
	assign tgt_oh   = (req_kind_q == bbc_pkg::KIND_ACQ && !any_hit) ? lru_oh : hit_oh;

	always_comb begin
		tgt_ent = '0;
		for (int i = 0; i < bbc_pkg::ENTRIES; i++) begin
			tgt_ent = tgt_ent | (ent[i] & {$bits(bbc_pkg::entry_t){tgt_oh[i]}});
		end
	end

	// released entry goes to the front with its count now zero
	always_comb begin
		mover     = tgt_ent;
		mover.cnt = '0;
	end

	always_comb begin
		do_op      = 1'b0;
		do_move    = 1'b0;
		op         = bbc_pkg::OP_HOLD;
		res_slot   = '0;
		res_need   = 1'b0;
		res_status = bbc_pkg::ST_OK;
		if (req_kind_q == bbc_pkg::KIND_ACQ) begin
			priority if (any_hit) begin
				do_op    = 1'b1;
				op       = bbc_pkg::OP_HIT;
				res_slot = tgt_ent.id;
				res_need = !tgt_ent.valid;
			end else if (any_free) begin
				do_op    = 1'b1;
				op       = bbc_pkg::OP_FILL;
				res_slot = tgt_ent.id;
				res_need = 1'b1;
			end else begin
				res_status = bbc_pkg::ST_NO_FREE;
			end
		end else begin
			res_slot = req_slot_q;
			priority if (!any_hit || tgt_ent.cnt == '0) begin
				res_status = bbc_pkg::ST_UNREF;
			end else if (tgt_ent.cnt == bbc_pkg::CNT_W'(1)) begin
				do_move = 1'b1;
			end else begin
				do_op = 1'b1;
				op    = bbc_pkg::OP_DROP;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < bbc_pkg::ENTRIES; i++) begin
			ctl[i].shift = commit && do_move && front_mask[i];
			ctl[i].op    = (commit && do_op && tgt_oh[i]) ? op : bbc_pkg::OP_HOLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_kind_q <= kind;
			req_dev_q  <= dev;
			req_blk_q  <= block_number;
			req_slot_q <= slot;
			match_q    <= match_v;
		end
		if (commit) begin
			slot_out_q  <= res_slot;
			need_read_q <= res_need;
			status_q    <= res_status;
		end
	end

	assign out_valid = out_valid_q;
	assign slot_out  = slot_out_q;
	assign need_read = need_read_q;
	assign status    = status_q;

endmodule
